// ===== design/lzss_pkg.sv =====
// Shared types and constants for the LZSS stream decompressor.
// No dependencies; the top level and the parser import this package.
package lzss_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;
  // Copy length: at most 31 from the length field plus the minimum match.
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned MAX_LEN_FIELD = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL   = 2'd0,
    CFG_GROUP   = 2'd1,
    CFG_LENBITS = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_FLAGS = 3'b001,
    PH_DATA  = 3'b010,
    PH_TOKLO = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_LIT  = 2'd1,
    CMD_COPY = 2'd2,
    CMD_ERR  = 2'd3
  } cmd_kind_e;

  // What the parser asks the copy/output side to do for one item.
  typedef struct packed {
    cmd_kind_e        kind;
    logic [LEN_W-1:0] len;
    logic [15:0]      copy_dist;
  } cmd_t;

endpackage

// ===== design/lzss_in_if.sv =====
// Input channel of the LZSS decompressor: one compressed byte per item.
// Standalone; no package dependency.
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== design/lzss_out_if.sv =====
// Output channel of the LZSS decompressor: one decompressed byte per item.
// Standalone; no package dependency.
interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       done_res;
  logic       error;

  modport source (output valid, output out_byte, output last_of_run, output done_res,
                  output error, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input done_res,
                  input error, output ready);
endinterface

// ===== design/lzss_stream_decompressor_unit.sv =====
// LZSS stream decompressor, top level.
// Uses lzss_pkg, lzss_in_if, lzss_out_if, lzss_parser and lzss_hist_ram.
// Usage:
//   Program total_output_size, flag_group_bits and length_bits through the
//   write port (cfg_we_i / cfg_idx_i / cfg_data_i) while the block is idle.
//   Feed the compressed payload (header removed) one byte per item on in_i.
//   Decompressed bytes leave on out_o with last_of_run on the final byte an
//   item produces, done_res on the byte that reaches the total size, and
//   error on a rejected back-reference (one result, byte zero).
// Timing:
//   Flag and token bytes are taken one per cycle while no copy runs and out_o
//   is not stalled. A literal appears on out_o in the cycle after its item is
//   accepted. Once the token's low byte is taken, a back-reference of n bytes
//   loads the copy counters, then the RAM read register, then the output register,
//   and emits one byte per cycle while out_o is not stalled; input is held off
//   until the copy is done. An overlapping copy is served by write-first forwarding in the RAM.
// Reset and stalls:
//   Reset clears the parser, counters and output valid; the history RAM is not
//   cleared and is never read before it is written. When out_o stalls, the
//   output register holds, the copy pauses and in_i.ready drops.
//   Once total_output_size bytes are out, further items are taken and dropped.
module lzss_stream_decompressor_unit #(
  parameter int unsigned HISTORY_DEPTH = 32768,
  parameter int unsigned MIN_MATCH     = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lzss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lzss_pkg::CFG_W-1:0]     cfg_data_i,
  lzss_in_if.sink                        in_i,
  lzss_out_if.source                     out_o
);
  import lzss_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic [31:0] total_q;
  logic [5:0]  group_q;
  logic [2:0]  lenbits_q;

  logic [AW-1:0]    wp_q, wp_inc;
  logic [31:0]      bw_q, bw_inc;
  logic [AW-1:0]    cp_rd_q, rd_next, start_addr;
  logic [LEN_W-1:0] issue_left_q, emit_left_q;
  logic             rv_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q, out_done_q, out_err_q;

  cmd_t       cmd;
  logic       out_free, busy, in_acc;
  logic       lit_go, err_go, copy_go, consume, issue;
  logic       mem_we;
  logic [7:0] mem_wdata, rd_data;
  logic [AW:0] wp_ext, dist_ext, wrap_add;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= 32'd0;
      group_q   <= 6'd8;
      lenbits_q <= 3'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TOTAL:   total_q   <= cfg_data_i;
        CFG_GROUP:   group_q   <= cfg_data_i[5:0];
        CFG_LENBITS: lenbits_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign busy       = emit_left_q != '0;
  assign in_i.ready = !busy && out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  lzss_parser #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MIN_MATCH     (MIN_MATCH)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .in_byte_i     (in_i.in_byte),
    .group_bits_i  (group_q),
    .length_bits_i (lenbits_q),
    .total_i       (total_q),
    .written_i     (bw_q),
    .cmd_o         (cmd)
  );

  assign lit_go  = in_acc && cmd.kind == CMD_LIT;
  assign err_go  = in_acc && cmd.kind == CMD_ERR;
  assign copy_go = in_acc && cmd.kind == CMD_COPY;

  // copy engine: rv_q marks a history byte waiting in the RAM read register
  assign consume = rv_q && out_free;
  assign issue   = (issue_left_q != '0) && (!rv_q || consume);

  assign mem_we    = lit_go || consume;
  assign mem_wdata = lit_go ? in_i.in_byte : rd_data;

  assign wp_inc  = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
  assign rd_next = (cp_rd_q == AW'(HISTORY_DEPTH - 1)) ? '0 : cp_rd_q + AW'(1);
  assign bw_inc  = bw_q + 32'd1;

  // start = (wp - dist) mod depth; dist is already checked to be within depth
  assign wp_ext     = {1'b0, wp_q};
  assign dist_ext   = cmd.copy_dist[AW:0];
  assign wrap_add   = (wp_ext < dist_ext) ? (AW+1)'(HISTORY_DEPTH) : '0;
  assign start_addr = AW'(wp_ext + wrap_add - dist_ext);

  lzss_hist_ram #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (cp_rd_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      bw_q         <= 32'd0;
      cp_rd_q      <= '0;
      issue_left_q <= '0;
      emit_left_q  <= '0;
      rv_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (mem_we) begin
        wp_q <= wp_inc;
        bw_q <= bw_inc;
      end
      if (copy_go) begin
        cp_rd_q      <= start_addr;
        issue_left_q <= cmd.len;
        emit_left_q  <= cmd.len;
      end else begin
        if (issue) begin
          cp_rd_q      <= rd_next;
          issue_left_q <= issue_left_q - LEN_W'(1);
        end
        if (consume) begin
          emit_left_q <= emit_left_q - LEN_W'(1);
        end
      end
      if (issue) begin
        rv_q <= 1'b1;
      end else if (consume) begin
        rv_q <= 1'b0;
      end
      if (lit_go || err_go || consume) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (lit_go) begin
      out_byte_q <= in_i.in_byte;
      out_last_q <= 1'b1;
      out_done_q <= bw_inc == total_q;
      out_err_q  <= 1'b0;
    end else if (err_go) begin
      out_byte_q <= 8'd0;
      out_last_q <= 1'b1;
      out_done_q <= 1'b0;
      out_err_q  <= 1'b1;
    end else if (consume) begin
      out_byte_q <= rd_data;
      out_last_q <= emit_left_q == LEN_W'(1);
      out_done_q <= bw_inc == total_q;
      out_err_q  <= 1'b0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.done_res    = out_done_q;
  assign out_o.error       = out_err_q;

  // bytes still to emit = reads still to issue + the one waiting in the RAM
  a_copy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_left_q == issue_left_q + LEN_W'(rv_q))
    else $error("copy counters out of step");

  a_one_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({lit_go, err_go, consume}))
    else $error("two sources load the output register at once");

  a_wr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> bw_q == $past(bw_q) + 32'd1)
    else $error("history write without byte count advance");

  a_copy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_go |=> busy && !rv_q)
    else $error("copy did not start cleanly");

endmodule

// ===== design/lzss_hist_ram.sv =====
// History store: one write port, one registered read port.
// A read of the address written in the same cycle returns the new byte.
module lzss_hist_ram #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // write-first forwarding for overlapping copies (distance one)
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= (we_i && waddr_i == raddr_i) ? wdata_i : mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lzss_parser.sv =====
// Flag/token parser: tracks flag groups and token bytes, decodes tokens.
// Depends on lzss_pkg.
module lzss_parser #(
  parameter int unsigned HISTORY_DEPTH = 32768,
  parameter int unsigned MIN_MATCH     = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic [5:0]    group_bits_i,
  input  logic [2:0]    length_bits_i,
  input  logic [31:0]   total_i,
  input  logic [31:0]   written_i,
  output lzss_pkg::cmd_t cmd_o
);
  import lzss_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] shift_q, shift_d;
  logic [5:0]  left_q, left_d;
  logic [2:0]  loaded_q, loaded_d;
  logic [7:0]  tokh_q, tokh_d;

  logic [2:0]       nbytes;
  logic [5:0]       grp_len;
  logic             finished;
  logic             consume;
  cmd_kind_e        kind;
  logic [15:0]      tok_word;
  logic [2:0]       lb;
  logic [4:0]       len_mask;
  logic [LEN_W-1:0] len_raw;
  logic [15:0]      copy_dist;
  logic [31:0]      remaining;
  logic             dist_bad;

  assign nbytes   = group_bits_i[5:3];
  assign grp_len  = (group_bits_i == 6'd0) ? 6'd1 : group_bits_i;
  assign finished = written_i >= total_i;

  // token decode
  assign tok_word  = {tokh_q, in_byte_i};
  assign lb        = (length_bits_i > 3'(MAX_LEN_FIELD)) ? 3'(MAX_LEN_FIELD) : length_bits_i;
  assign len_mask  = 5'((6'd1 << lb) - 6'd1);
  assign len_raw   = LEN_W'(tok_word[4:0] & len_mask) + LEN_W'(MIN_MATCH);
  assign copy_dist = tok_word >> lb;
  assign remaining = total_i - written_i;
  assign dist_bad  = (copy_dist == 16'd0) || (32'(copy_dist) > written_i) ||
                     (32'(copy_dist) > 32'(HISTORY_DEPTH));

  always_comb begin
    phase_d  = phase_q;
    shift_d  = shift_q;
    left_d   = left_q;
    loaded_d = loaded_q;
    tokh_d   = tokh_q;
    kind     = CMD_NONE;
    consume  = 1'b0;

    // outside data/token phases: collect flags, or start data if none are due
    if (phase_d != PH_DATA && phase_d != PH_TOKLO) begin
      phase_d = PH_FLAGS;
      if (loaded_d >= nbytes) begin
        phase_d = PH_DATA;
        left_d  = grp_len;
      end
    end

    if (phase_d == PH_FLAGS) begin
      if (loaded_d < 3'd4) begin
        shift_d = shift_d | (32'(in_byte_i) << {loaded_d[1:0], 3'b000});
      end
      loaded_d = loaded_d + 3'd1;
      if (loaded_d >= nbytes) begin
        loaded_d = 3'd0;
        phase_d  = PH_DATA;
        left_d   = grp_len;
      end
    end else if (phase_d == PH_DATA) begin
      if (shift_d[0]) begin
        kind    = CMD_LIT;
        consume = 1'b1;
      end else begin
        tokh_d  = in_byte_i;
        phase_d = PH_TOKLO;
      end
    end else begin
      kind    = dist_bad ? CMD_ERR : CMD_COPY;
      consume = 1'b1;
    end

    if (consume) begin
      shift_d = shift_d >> 1;
      if (left_d != 6'd0) begin
        left_d = left_d - 6'd1;
      end
      if (left_d == 6'd0) begin
        shift_d  = 32'd0;
        loaded_d = 3'd0;
        if (nbytes == 3'd0) begin
          phase_d = PH_DATA;
          left_d  = grp_len;
        end else begin
          phase_d = PH_FLAGS;
        end
      end else begin
        phase_d = PH_DATA;
      end
    end

    if (finished) begin
      kind = CMD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FLAGS;
      shift_q  <= 32'd0;
      left_q   <= 6'd0;
      loaded_q <= 3'd0;
      tokh_q   <= 8'd0;
    end else if (accept_i && !finished) begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      left_q   <= left_d;
      loaded_q <= loaded_d;
      tokh_q   <= tokh_d;
    end
  end

  assign cmd_o.kind      = kind;
  assign cmd_o.len       = (remaining < 32'(len_raw)) ? remaining[LEN_W-1:0] : len_raw;
  assign cmd_o.copy_dist = copy_dist;

endmodule
